// ===== src/wdc_alu_pkg.sv =====
// wdc_alu_pkg: operation codes, bcd adjust constants and stage payload types
// for the 65816-style alu pipeline. no dependencies.

package wdc_alu_pkg;

   typedef enum logic [3:0] {
      OP_ADC = 4'd0,
      OP_SBC = 4'd1,
      OP_AND = 4'd2,
      OP_OR  = 4'd3,
      OP_XOR = 4'd4,
      OP_CMP = 4'd5,
      OP_ASL = 4'd6,
      OP_LSR = 4'd7,
      OP_ROL = 4'd8,
      OP_ROR = 4'd9,
      OP_INC = 4'd10,
      OP_DEC = 4'd11,
      OP_BIT = 4'd12,
      OP_TRB = 4'd13,
      OP_TSB = 4'd14
   } op_type;

   typedef enum logic [1:0] {
      SEL_SIMPLE = 2'd0,
      SEL_ADD    = 2'd1,
      SEL_SUB    = 2'd2
   } sel_type;

   localparam logic [15:0] BcdLimit [4] = '{16'h0009, 16'h009f, 16'h09ff, 16'h9fff};
   localparam logic [15:0] BcdFix   [4] = '{16'h0006, 16'h0060, 16'h0600, 16'h6000};

   typedef struct packed {
      logic value;
      logic carry;
      logic overflow;
      logic zero;
      logic negative;
   } mark_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic        wide;
      logic [15:0] left_operand;
      logic [15:0] right_operand;
      logic        carry_flag;
      logic        decimal_mode;
      logic        bit_memory;
   } req_type;

   typedef struct packed {
      sel_type     sel;
      logic        wide;
      logic        dec;
      mark_type    mark;
      logic        nz_from_val;
      logic [15:0] val;
      logic        c;
      logic        v;
      logic        z;
      logic        n;
      logic [15:0] l;
      logic [15:0] r;
      logic        cin;
      logic        b;
      logic [16:0] sum_bin;
      logic [16:0] diff;
      logic [15:0] add_adj;
      logic [15:0] sub_adj;
   } s1_type;

   typedef struct packed {
      sel_type     sel;
      logic        wide;
      mark_type    mark;
      logic        nz_from_val;
      logic [15:0] val;
      logic        c;
      logic        v;
      logic        z;
      logic        n;
      logic [16:0] sum_bin;
      logic [15:0] diff;
      logic [15:0] add_adj;
      logic [15:0] sub_adj;
   } s2_type;

   typedef struct packed {
      logic [15:0] value;
      mark_type    mark;
      logic        c;
      logic        v;
      logic        z;
      logic        n;
   } rsp_type;

   function automatic logic [15:0] mask_of(input logic [15:0] x, input logic wide);
      mask_of = wide ? x : {8'h00, x[7:0]};
   endfunction

   function automatic logic sign_of(input logic [15:0] x, input logic wide);
      sign_of = wide ? x[15] : x[7];
   endfunction

endpackage

// ===== src/wdc_alu_decode.sv =====
// wdc_alu_decode: first stage, decodes the operation, forms logic and shift
// results, binary sum and difference and the low two bcd digit adjusts.
// depends on wdc_alu_pkg.

module wdc_alu_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  wdc_alu_pkg::req_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output wdc_alu_pkg::s1_type out_data
);

   logic                valid_ff;
   wdc_alu_pkg::s1_type data_ff;
   wdc_alu_pkg::s1_type data_in;

   logic [15:0] l;
   logic [15:0] r;
   logic        cin;
   logic        b;
   logic        dec;
   logic        wide;
   logic [16:0] sum_bin;
   logic [16:0] diff;
   logic [16:0] cmp_diff;
   logic [4:0]  part0;
   logic [9:0]  part1;
   logic [15:0] adj0;
   logic [15:0] adj1;
   logic        bor0;
   logic        bor1;

   assign wide = in_data.wide;
   assign dec  = in_data.decimal_mode;
   assign cin  = in_data.carry_flag;
   assign b    = ~in_data.carry_flag;
   assign l    = wdc_alu_pkg::mask_of(in_data.left_operand, wide);
   assign r    = wdc_alu_pkg::mask_of(in_data.right_operand, wide);

   assign sum_bin  = {1'b0, l} + {1'b0, r} + {16'h0000, cin};
   assign diff     = {1'b0, l} - {1'b0, r} - {16'h0000, b};
   assign cmp_diff = {1'b0, l} - {1'b0, r};

   // low two digits of the decimal adjust
   assign part0 = {1'b0, l[3:0]} + {1'b0, r[3:0]} + {4'h0, cin};
   assign adj0  = (dec && ({11'h000, part0} > wdc_alu_pkg::BcdLimit[0]))
                  ? wdc_alu_pkg::BcdFix[0] : 16'h0000;
   assign part1 = {2'b00, l[7:0]} + {2'b00, r[7:0]} + {9'h000, cin} + adj0[9:0];
   assign adj1  = adj0 + ((dec && ({6'h00, part1} > wdc_alu_pkg::BcdLimit[1]))
                  ? wdc_alu_pkg::BcdFix[1] : 16'h0000);
   assign bor0  = {1'b0, l[3:0]} < ({1'b0, r[3:0]} + {4'h0, b});
   assign bor1  = {1'b0, l[7:0]} < ({1'b0, r[7:0]} + {8'h00, b});

   always_comb begin
      data_in         = '0;
      data_in.sel     = wdc_alu_pkg::SEL_SIMPLE;
      data_in.wide    = wide;
      data_in.dec     = dec;
      data_in.l       = l;
      data_in.r       = r;
      data_in.cin     = cin;
      data_in.b       = b;
      data_in.sum_bin = sum_bin;
      data_in.diff    = diff;
      data_in.add_adj = adj1;
      data_in.sub_adj = ((dec && bor0) ? wdc_alu_pkg::BcdFix[0] : 16'h0000)
                      + ((dec && bor1) ? wdc_alu_pkg::BcdFix[1] : 16'h0000);
      unique case (wdc_alu_pkg::op_type'(in_data.operation))
         wdc_alu_pkg::OP_ADC: begin
            data_in.sel         = wdc_alu_pkg::SEL_ADD;
            data_in.v           = wdc_alu_pkg::sign_of(~(l ^ r) & (l ^ sum_bin[15:0]), wide);
            data_in.mark        = '{value: 1'b1, carry: 1'b1, overflow: 1'b1,
                                    zero: 1'b1, negative: 1'b1};
            data_in.nz_from_val = 1'b1;
         end
         wdc_alu_pkg::OP_SBC: begin
            data_in.sel         = wdc_alu_pkg::SEL_SUB;
            data_in.v           = wdc_alu_pkg::sign_of((l ^ r) & (l ^ diff[15:0]), wide);
            data_in.c           = ~diff[16];
            data_in.mark        = '{value: 1'b1, carry: 1'b1, overflow: 1'b1,
                                    zero: 1'b1, negative: 1'b1};
            data_in.nz_from_val = 1'b1;
         end
         wdc_alu_pkg::OP_AND, wdc_alu_pkg::OP_OR, wdc_alu_pkg::OP_XOR,
         wdc_alu_pkg::OP_INC, wdc_alu_pkg::OP_DEC: begin
            unique case (wdc_alu_pkg::op_type'(in_data.operation))
               wdc_alu_pkg::OP_AND: data_in.val = l & r;
               wdc_alu_pkg::OP_OR:  data_in.val = l | r;
               wdc_alu_pkg::OP_XOR: data_in.val = l ^ r;
               wdc_alu_pkg::OP_INC: data_in.val = wdc_alu_pkg::mask_of(l + 16'h0001, wide);
               default:             data_in.val = wdc_alu_pkg::mask_of(l - 16'h0001, wide);
            endcase
            data_in.mark        = '{value: 1'b1, carry: 1'b0, overflow: 1'b0,
                                    zero: 1'b1, negative: 1'b1};
            data_in.nz_from_val = 1'b1;
         end
         wdc_alu_pkg::OP_CMP: begin
            data_in.val         = wdc_alu_pkg::mask_of(cmp_diff[15:0], wide);
            data_in.c           = ~cmp_diff[16];
            data_in.mark        = '{value: 1'b0, carry: 1'b1, overflow: 1'b0,
                                    zero: 1'b1, negative: 1'b1};
            data_in.nz_from_val = 1'b1;
         end
         wdc_alu_pkg::OP_ASL, wdc_alu_pkg::OP_ROL: begin
            data_in.c   = wdc_alu_pkg::sign_of(l, wide);
            data_in.val = wdc_alu_pkg::mask_of({l[14:0], 1'b0} |
               {15'h0000, (in_data.operation == wdc_alu_pkg::OP_ROL) & cin}, wide);
            data_in.mark        = '{value: 1'b1, carry: 1'b1, overflow: 1'b0,
                                    zero: 1'b1, negative: 1'b1};
            data_in.nz_from_val = 1'b1;
         end
         wdc_alu_pkg::OP_LSR, wdc_alu_pkg::OP_ROR: begin
            data_in.c   = l[0];
            data_in.val = {1'b0, l[15:1]};
            if ((in_data.operation == wdc_alu_pkg::OP_ROR) && cin) begin
               if (wide) begin
                  data_in.val[15] = 1'b1;
               end else begin
                  data_in.val[7] = 1'b1;
               end
            end
            data_in.mark        = '{value: 1'b1, carry: 1'b1, overflow: 1'b0,
                                    zero: 1'b1, negative: 1'b1};
            data_in.nz_from_val = 1'b1;
         end
         wdc_alu_pkg::OP_BIT: begin
            data_in.z    = (l & r) == 16'h0000;
            data_in.n    = wdc_alu_pkg::sign_of(r, wide);
            data_in.v    = wide ? r[14] : r[6];
            data_in.mark = '{value: 1'b0, carry: 1'b0, overflow: in_data.bit_memory,
                             zero: 1'b1, negative: in_data.bit_memory};
         end
         wdc_alu_pkg::OP_TRB, wdc_alu_pkg::OP_TSB: begin
            data_in.z    = (l & r) == 16'h0000;
            data_in.val  = (in_data.operation == wdc_alu_pkg::OP_TRB) ? (r & ~l) : (r | l);
            data_in.mark = '{value: 1'b1, carry: 1'b0, overflow: 1'b0,
                             zero: 1'b1, negative: 1'b0};
         end
         default: begin
            data_in.mark = '0;
         end
      endcase
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/wdc_alu_adjust.sv =====
// wdc_alu_adjust: second stage, upper two bcd digit adjusts for add and
// subtract in 16-bit decimal mode. depends on wdc_alu_pkg.

module wdc_alu_adjust (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  wdc_alu_pkg::s1_type in_data,
   output logic                out_valid,
   input  logic                out_stall,
   output wdc_alu_pkg::s2_type out_data
);

   logic                valid_ff;
   wdc_alu_pkg::s2_type data_ff;
   wdc_alu_pkg::s2_type data_in;

   logic        go;
   logic [13:0] part2;
   logic [15:0] adj2;
   logic [17:0] part3;
   logic [15:0] adj3;
   logic        bor2;
   logic        bor3;

   assign go    = in_data.wide && in_data.dec;
   assign part2 = {2'b00, in_data.l[11:0]} + {2'b00, in_data.r[11:0]}
                + {13'h0000, in_data.cin} + in_data.add_adj[13:0];
   assign adj2  = in_data.add_adj + ((go && ({2'b00, part2} > wdc_alu_pkg::BcdLimit[2]))
                  ? wdc_alu_pkg::BcdFix[2] : 16'h0000);
   assign part3 = {1'b0, in_data.sum_bin} + {2'b00, adj2};
   assign adj3  = adj2 + ((go && (part3 > {2'b00, wdc_alu_pkg::BcdLimit[3]}))
                  ? wdc_alu_pkg::BcdFix[3] : 16'h0000);
   assign bor2  = {1'b0, in_data.l[11:0]} < ({1'b0, in_data.r[11:0]} + {12'h000, in_data.b});
   assign bor3  = in_data.diff[16];

   always_comb begin
      data_in.sel         = in_data.sel;
      data_in.wide        = in_data.wide;
      data_in.mark        = in_data.mark;
      data_in.nz_from_val = in_data.nz_from_val;
      data_in.val         = in_data.val;
      data_in.c           = in_data.c;
      data_in.v           = in_data.v;
      data_in.z           = in_data.z;
      data_in.n           = in_data.n;
      data_in.sum_bin     = in_data.sum_bin;
      data_in.diff        = in_data.diff[15:0];
      data_in.add_adj     = adj3;
      data_in.sub_adj     = in_data.sub_adj
                          + ((go && bor2) ? wdc_alu_pkg::BcdFix[2] : 16'h0000)
                          + ((go && bor3) ? wdc_alu_pkg::BcdFix[3] : 16'h0000);
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/wdc_alu_resolve.sv =====
// wdc_alu_resolve: last stage, applies the adjusts, picks the value, forms
// n, z and the add carry, gates unwritten outputs. depends on wdc_alu_pkg.

module wdc_alu_resolve (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_stall,
   input  wdc_alu_pkg::s2_type  in_data,
   output logic                 out_valid,
   input  logic                 out_stall,
   output wdc_alu_pkg::rsp_type out_data
);

   logic                 valid_ff;
   wdc_alu_pkg::rsp_type data_ff;
   wdc_alu_pkg::rsp_type data_in;

   logic [17:0] t;
   logic        add_c;
   logic [15:0] val_sub;
   logic [15:0] val;
   logic        c;
   logic        z;
   logic        n;

   assign t       = {1'b0, in_data.sum_bin} + {2'b00, in_data.add_adj};
   assign add_c   = in_data.wide ? (|t[17:16]) : (|t[17:8]);
   assign val_sub = in_data.diff - in_data.sub_adj;

   always_comb begin
      unique case (in_data.sel)
         wdc_alu_pkg::SEL_ADD: begin
            val = wdc_alu_pkg::mask_of(t[15:0], in_data.wide);
            c   = add_c;
         end
         wdc_alu_pkg::SEL_SUB: begin
            val = wdc_alu_pkg::mask_of(val_sub, in_data.wide);
            c   = in_data.c;
         end
         default: begin
            val = in_data.val;
            c   = in_data.c;
         end
      endcase
      z = in_data.nz_from_val ? (val == 16'h0000) : in_data.z;
      n = in_data.nz_from_val ? wdc_alu_pkg::sign_of(val, in_data.wide) : in_data.n;

      data_in.value = in_data.mark.value ? val : 16'h0000;
      data_in.mark  = in_data.mark;
      data_in.c     = in_data.mark.carry && c;
      data_in.v     = in_data.mark.overflow && in_data.v;
      data_in.z     = in_data.mark.zero && z;
      data_in.n     = in_data.mark.negative && n;
   end

   assign in_stall = valid_ff && out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== src/wdc65816_alu_with_bcd.sv =====
// wdc65816_alu_with_bcd: top level of the 65816-style alu with bcd add and
// subtract. depends on wdc_alu_pkg, wdc_alu_decode, wdc_alu_adjust, wdc_alu_resolve.
//
// usage:
//  - req channel: one beat carries operation, width, two operands, carry,
//    decimal and memory-form flags. a beat is taken when req_valid is high
//    and req_stall is low.
//  - rsp channel: one beat per request, in order, carrying the value, the
//    new n, v, z, c and a written mark for the value and each flag.
//  - pipeline: three register stages: decode and low bcd digits, upper bcd
//    digits, final adjust and flag forming, the first loaded at the accepting
//    edge; rsp_valid rises once the beat is held in the last of them.
//  - throughput is one beat per cycle; a new beat enters every cycle while
//    the pipeline moves.
//  - a stall on rsp holds the output register; stages behind it keep
//    filling bubbles, and req_stall rises only when all three are full.
//  - synchronous reset empties the pipeline; no configuration, no state
//    beyond the beats in flight.

module wdc65816_alu_with_bcd (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_operation,
   input  logic        req_wide,
   input  logic [15:0] req_left_operand,
   input  logic [15:0] req_right_operand,
   input  logic        req_carry_flag,
   input  logic        req_decimal_mode,
   input  logic        req_bit_memory,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_result_value,
   output logic        rsp_result_written,
   output logic        rsp_carry_out,
   output logic        rsp_overflow_out,
   output logic        rsp_zero_out,
   output logic        rsp_negative_out,
   output logic        rsp_carry_written,
   output logic        rsp_overflow_written,
   output logic        rsp_zero_written,
   output logic        rsp_negative_written
);

   wdc_alu_pkg::req_type req;
   wdc_alu_pkg::s1_type  s1_data;
   wdc_alu_pkg::s2_type  s2_data;
   wdc_alu_pkg::rsp_type rsp;
   logic                 s1_valid;
   logic                 s1_stall;
   logic                 s2_valid;
   logic                 s2_stall;

   assign req.operation     = req_operation;
   assign req.wide          = req_wide;
   assign req.left_operand  = req_left_operand;
   assign req.right_operand = req_right_operand;
   assign req.carry_flag    = req_carry_flag;
   assign req.decimal_mode  = req_decimal_mode;
   assign req.bit_memory    = req_bit_memory;

   wdc_alu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req),
      .out_valid (s1_valid),
      .out_stall (s1_stall),
      .out_data  (s1_data)
   );

   wdc_alu_adjust u_adjust (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_stall  (s1_stall),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_stall (s2_stall),
      .out_data  (s2_data)
   );

   wdc_alu_resolve u_resolve (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_stall  (s2_stall),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp)
   );

   assign rsp_result_value     = rsp.value;
   assign rsp_result_written   = rsp.mark.value;
   assign rsp_carry_out        = rsp.c;
   assign rsp_overflow_out     = rsp.v;
   assign rsp_zero_out         = rsp.z;
   assign rsp_negative_out     = rsp.n;
   assign rsp_carry_written    = rsp.mark.carry;
   assign rsp_overflow_written = rsp.mark.overflow;
   assign rsp_zero_written     = rsp.mark.zero;
   assign rsp_negative_written = rsp.mark.negative;

   a_value_gated: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_written) |-> (rsp_result_value == 16'h0000))
      else $error("value present without written mark");

   a_flags_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_carry_written || !rsp_carry_out)
                  && (rsp_overflow_written || !rsp_overflow_out)
                  && (rsp_zero_written || !rsp_zero_out)
                  && (rsp_negative_written || !rsp_negative_out)))
      else $error("flag set without written mark");

   a_neg_implies_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_negative_written) |-> rsp_zero_written)
      else $error("n written without z");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall) |=> rsp_valid)
      else $error("beat did not reach output in three cycles");

endmodule

// ===== bench/tb_wdc65816_alu_with_bcd.sv =====
// tb_wdc65816_alu_with_bcd: self-checking bench for the 65816-style alu, a directed table
// followed by ~1600 random beats with bursty sends and patterned rsp stalls.
// depends on wdc_alu_pkg and wdc65816_alu_with_bcd.

module tb_wdc65816_alu_with_bcd;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] OpUnused = 4'd15;
   localparam int RandomBeats = 1625;
   localparam int IdleLimit = 2000;
   localparam int DrainCycles = 8;

   localparam logic [17:0] DigitMask  [4] = '{18'h0000f, 18'h000ff, 18'h00fff, 18'h0ffff};
   localparam logic [17:0] DigitLimit [4] = '{18'h00009, 18'h0009f, 18'h009ff, 18'h09fff};
   localparam logic [17:0] DigitFix   [4] = '{18'h00006, 18'h00060, 18'h00600, 18'h06000};

   typedef struct packed {
      logic [15:0] value;
      logic        written;
      logic        carry;
      logic        overflow;
      logic        zero;
      logic        negative;
      logic        carry_w;
      logic        overflow_w;
      logic        zero_w;
      logic        negative_w;
   } outcome_type;

   typedef struct {
      wdc_alu_pkg::req_type q;
      bit                   fixed;
      outcome_type          want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_operation = '0;
   logic        req_wide = 1'b0;
   logic [15:0] req_left_operand = '0;
   logic [15:0] req_right_operand = '0;
   logic        req_carry_flag = 1'b0;
   logic        req_decimal_mode = 1'b0;
   logic        req_bit_memory = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_result_value;
   logic        rsp_result_written;
   logic        rsp_carry_out;
   logic        rsp_overflow_out;
   logic        rsp_zero_out;
   logic        rsp_negative_out;
   logic        rsp_carry_written;
   logic        rsp_overflow_written;
   logic        rsp_zero_written;
   logic        rsp_negative_written;

   outcome_type pending_outcomes [$];
   int          mismatches = 0;
   int          idle_count = 0;
   int          stall_mode = 0;
   int          stall_phase = 0;
   int          cycle_count = 0;

   stim_row_type directed_rows [25] = '{
      '{'{wdc_alu_pkg::OP_ADC, 1'b0, 16'h007f, 16'h0001, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{16'h0080, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{wdc_alu_pkg::OP_ADC, 1'b1, 16'hffff, 16'hffff, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{16'hffff, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{wdc_alu_pkg::OP_ADC, 1'b0, 16'hab99, 16'h5501, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_ADC, 1'b1, 16'h9999, 16'h0001, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_ADC, 1'b0, 16'h00ff, 16'h00ff, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_SBC, 1'b0, 16'h0000, 16'h0001, 1'b1, 1'b0, 1'b0}, 1'b1,
        '{16'h00ff, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}},
      '{'{wdc_alu_pkg::OP_SBC, 1'b0, 16'hff00, 16'h0001, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_SBC, 1'b1, 16'h1000, 16'h0001, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_SBC, 1'b1, 16'h8000, 16'h0001, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_AND, 1'b0, 16'hff00, 16'h00ff, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{'{wdc_alu_pkg::OP_OR,  1'b1, 16'hffff, 16'h0000, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_XOR, 1'b1, 16'haaaa, 16'h5555, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_CMP, 1'b0, 16'h0010, 16'h0020, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_CMP, 1'b1, 16'h1234, 16'h1234, 1'b0, 1'b1, 1'b0}, 1'b1,
        '{16'h0000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}},
      '{'{wdc_alu_pkg::OP_ASL, 1'b1, 16'h8001, 16'hffff, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_LSR, 1'b0, 16'hff01, 16'h0000, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_ROL, 1'b0, 16'h0080, 16'h0000, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_ROR, 1'b1, 16'h0001, 16'h0000, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_INC, 1'b1, 16'hffff, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b1,
        '{16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}},
      '{'{wdc_alu_pkg::OP_DEC, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_BIT, 1'b0, 16'hff00, 16'h00c0, 1'b0, 1'b0, 1'b1}, 1'b1,
        '{16'h0000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1}},
      '{'{wdc_alu_pkg::OP_BIT, 1'b1, 16'hffff, 16'h4000, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_TRB, 1'b1, 16'h00ff, 16'hffff, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{wdc_alu_pkg::OP_TSB, 1'b0, 16'h000f, 16'h00f0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{OpUnused, 1'b1, 16'hffff, 16'hffff, 1'b1, 1'b1, 1'b1}, 1'b1, '0}
   };

   wdc65816_alu_with_bcd dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_wide             (req_wide),
      .req_left_operand     (req_left_operand),
      .req_right_operand    (req_right_operand),
      .req_carry_flag       (req_carry_flag),
      .req_decimal_mode     (req_decimal_mode),
      .req_bit_memory       (req_bit_memory),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_result_value     (rsp_result_value),
      .rsp_result_written   (rsp_result_written),
      .rsp_carry_out        (rsp_carry_out),
      .rsp_overflow_out     (rsp_overflow_out),
      .rsp_zero_out         (rsp_zero_out),
      .rsp_negative_out     (rsp_negative_out),
      .rsp_carry_written    (rsp_carry_written),
      .rsp_overflow_written (rsp_overflow_written),
      .rsp_zero_written     (rsp_zero_written),
      .rsp_negative_written (rsp_negative_written)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic outcome_type alu_outcome(input wdc_alu_pkg::req_type q);
      logic [17:0] mask, sgn, l, r, t, val, adj, part, cin, b;
      logic        c, v, z, n, wv, wc, wo, wz, wn, nz;
      integer      k, ndig;
      outcome_type o;
      mask = q.wide ? 18'h0ffff : 18'h000ff;
      sgn  = q.wide ? 18'h08000 : 18'h00080;
      ndig = q.wide ? 4 : 2;
      l    = {2'b00, q.left_operand} & mask;
      r    = {2'b00, q.right_operand} & mask;
      cin  = {17'd0, q.carry_flag};
      b    = {17'd0, ~q.carry_flag};
      {c, v, z, n, wv, wc, wo, wz, wn, nz} = '0;
      t   = '0;
      val = '0;
      adj = '0;
      case (q.operation)
         wdc_alu_pkg::OP_ADC: begin
            t = l + r + cin;
            v = |(~(l ^ r) & (l ^ t) & sgn);
            if (q.decimal_mode) begin
               for (k = 0; k < ndig; k++) begin
                  part = (l & DigitMask[k]) + (r & DigitMask[k]) + cin + adj;
                  if (part > DigitLimit[k]) adj = adj + DigitFix[k];
               end
               t = l + r + cin + adj;
            end
            c   = t > mask;
            val = t & mask;
            {wv, wc, wo, nz} = 4'b1111;
         end
         wdc_alu_pkg::OP_SBC: begin
            t = (l - r - b) & mask;
            v = |((l ^ r) & (l ^ t) & sgn);
            if (q.decimal_mode) begin
               t = l - r - b;
               for (k = 0; k < ndig; k++) begin
                  if ((l & DigitMask[k]) < (r & DigitMask[k]) + b) t = t - DigitFix[k];
               end
            end
            c   = l >= r + b;
            val = t & mask;
            {wv, wc, wo, nz} = 4'b1111;
         end
         wdc_alu_pkg::OP_AND: begin val = l & r; {wv, nz} = 2'b11; end
         wdc_alu_pkg::OP_OR:  begin val = l | r; {wv, nz} = 2'b11; end
         wdc_alu_pkg::OP_XOR: begin val = l ^ r; {wv, nz} = 2'b11; end
         wdc_alu_pkg::OP_CMP: begin
            t = (l - r) & mask;
            c = l >= r;
            z = t == 0;
            n = |(t & sgn);
            {wc, wz, wn} = 3'b111;
         end
         wdc_alu_pkg::OP_ASL, wdc_alu_pkg::OP_ROL: begin
            c   = |(l & sgn);
            val = ((l << 1) | ((q.operation == wdc_alu_pkg::OP_ROL) ? cin : 18'd0)) & mask;
            {wv, wc, nz} = 3'b111;
         end
         wdc_alu_pkg::OP_LSR, wdc_alu_pkg::OP_ROR: begin
            c   = l[0];
            val = ((l >> 1)
                  | ((q.operation == wdc_alu_pkg::OP_ROR && q.carry_flag) ? sgn : 18'd0))
                  & mask;
            {wv, wc, nz} = 3'b111;
         end
         wdc_alu_pkg::OP_INC: begin val = (l + 18'd1) & mask; {wv, nz} = 2'b11; end
         wdc_alu_pkg::OP_DEC: begin val = (l - 18'd1) & mask; {wv, nz} = 2'b11; end
         wdc_alu_pkg::OP_BIT: begin
            z  = (l & r) == 0;
            wz = 1'b1;
            if (q.bit_memory) begin
               n = |(r & sgn);
               v = |(r & (sgn >> 1));
               {wn, wo} = 2'b11;
            end
         end
         wdc_alu_pkg::OP_TRB: begin
            z   = (l & r) == 0;
            val = r & ~l & mask;
            {wz, wv} = 2'b11;
         end
         wdc_alu_pkg::OP_TSB: begin
            z   = (l & r) == 0;
            val = (r | l) & mask;
            {wz, wv} = 2'b11;
         end
         default: ;
      endcase
      if (nz) begin
         z  = val == 0;
         n  = |(val & sgn);
         wz = 1'b1;
         wn = 1'b1;
      end
      o.value      = wv ? val[15:0] : 16'h0000;
      o.written    = wv;
      o.carry      = wc & c;
      o.overflow   = wo & v;
      o.zero       = wz & z;
      o.negative   = wn & n;
      o.carry_w    = wc;
      o.overflow_w = wo;
      o.zero_w     = wz;
      o.negative_w = wn;
      return o;
   endfunction

   function automatic logic [15:0] random_operand();
      logic [15:0] x;
      integer      k;
      x = 16'($urandom());
      case ($urandom_range(0, 9))
         0, 1, 2, 3: ;
         4, 5, 6: begin
            for (k = 0; k < 4; k++) x[k*4 +: 4] = 4'($urandom_range(0, 9));
         end
         7: x = 16'h0000;
         8: x[7:0] = ($urandom_range(0, 1) == 0) ? 8'h7f : 8'h80;
         default: x = ($urandom_range(0, 1) == 0) ? 16'hffff : 16'h8000 ^ 16'($urandom_range(0, 1));
      endcase
      return x;
   endfunction

   function automatic wdc_alu_pkg::req_type random_request();
      wdc_alu_pkg::req_type q;
      int                   pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         q.operation = ($urandom_range(0, 1) == 0) ? wdc_alu_pkg::OP_ADC : wdc_alu_pkg::OP_SBC;
      end else if (pick < 97) begin
         q.operation = 4'($urandom_range(wdc_alu_pkg::OP_AND, wdc_alu_pkg::OP_TSB));
      end else begin
         q.operation = OpUnused;
      end
      q.wide          = 1'($urandom_range(0, 1));
      q.left_operand  = random_operand();
      q.right_operand = random_operand();
      q.carry_flag    = 1'($urandom_range(0, 1));
      q.decimal_mode  = ($urandom_range(0, 99) < 60);
      q.bit_memory    = 1'($urandom_range(0, 1));
      return q;
   endfunction

   task automatic drive_beat(input wdc_alu_pkg::req_type q, input outcome_type want);
      req_valid         <= 1'b1;
      req_operation     <= q.operation;
      req_wide          <= q.wide;
      req_left_operand  <= q.left_operand;
      req_right_operand <= q.right_operand;
      req_carry_flag    <= q.carry_flag;
      req_decimal_mode  <= q.decimal_mode;
      req_bit_memory    <= q.bit_memory;
      do @(posedge clock); while (req_stall);
      pending_outcomes.push_back(want);
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   task automatic check_field(input string field, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h got %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // rsp stall pattern: quiet, random, or periodic runs, switched every so often
   always @(posedge clock) begin
      cycle_count++;
      if (stall_phase == 0) begin
         stall_mode  = $urandom_range(0, 2);
         stall_phase = $urandom_range(20, 120);
      end
      stall_phase--;
      case (stall_mode)
         1:       rsp_stall <= ($urandom_range(0, 99) < 35);
         2:       rsp_stall <= ((cycle_count % 11) < 4);
         default: rsp_stall <= 1'b0;
      endcase
   end

   always @(posedge clock) begin
      outcome_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_result_value, rsp_result_written, rsp_carry_out, rsp_overflow_out,
                 rsp_zero_out, rsp_negative_out, rsp_carry_written, rsp_overflow_written,
                 rsp_zero_written, rsp_negative_written};
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result beat, expected none got value %h",
                     $time, rsp_result_value);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("value", want.value, got.value);
            check_field("value written", 16'(want.written), 16'(got.written));
            check_field("carry", 16'(want.carry), 16'(got.carry));
            check_field("overflow", 16'(want.overflow), 16'(got.overflow));
            check_field("zero", 16'(want.zero), 16'(got.zero));
            check_field("negative", 16'(want.negative), 16'(got.negative));
            check_field("carry written", 16'(want.carry_w), 16'(got.carry_w));
            check_field("overflow written", 16'(want.overflow_w), 16'(got.overflow_w));
            check_field("zero written", 16'(want.zero_w), 16'(got.zero_w));
            check_field("negative written", 16'(want.negative_w), 16'(got.negative_w));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count = 0;
      else idle_count++;
      if (idle_count >= IdleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int                   burst_left;
      wdc_alu_pkg::req_type q;
      outcome_type          want;
      burst_left = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         want = directed_rows[i].fixed ? directed_rows[i].want : alu_outcome(directed_rows[i].q);
         drive_beat(directed_rows[i].q, want);
      end
      drain_results();

      for (int i = 0; i < RandomBeats; i++) begin
         if (i == RandomBeats / 2) begin
            drain_results();
         end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 10));
         end
         if (burst_left > 0) burst_left--;
         q = random_request();
         drive_beat(q, alu_outcome(q));
      end

      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
